// ===== hdl/planar_sample_to_8bit_converter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the planar sample to 8-bit converter
// Simulation-only property checks; they collapse to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef PLANAR_SAMPLE_TO_8BIT_CONVERTER_ASSERT_SVH
`define PLANAR_SAMPLE_TO_8BIT_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PSC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define PSC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// Planar sample converter package
// Register indexes, mode codes and the control bundle shared by the modules.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SAMPLE_PRECISION = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_LAYOUT    = 2'd1;
   localparam logic [1:0] CSR_STACKED_16BIT    = 2'd2;

   // Sample precision codes; code zero behaves as 8-bit samples.
   localparam logic [1:0] PREC_8BIT  = 2'd1;
   localparam logic [1:0] PREC_16BIT = 2'd2;
   localparam logic [1:0] PREC_HALF  = 2'd3;

   // Output layout codes; every code other than planar swaps to blue first.
   localparam logic [1:0] LAYOUT_PLANAR = 2'd0;

   // Reset values of the configuration registers.
   localparam logic [1:0] RESET_PRECISION = PREC_16BIT;
   localparam logic [1:0] RESET_LAYOUT    = LAYOUT_PLANAR;

   // Per-sample conversion control.
   typedef struct packed {
      logic [1:0] precision;
      logic       stack;
   } conv_ctrl_type;

endpackage

// ===== hdl/psc_half_scale.sv =====
// ----------------------------------------------------------------------------
// Half-float scaler
// Multiplies a half-float by 255 or 65535, rounds to nearest even and clamps.
// ----------------------------------------------------------------------------
module psc_half_scale
   import psc_pkg::*;
(
   input  logic [15:0] half_bits,
   input  logic        wide,
   output logic [15:0] scaled
);

   logic        sgn;
   logic [4:0]  ex;
   logic [9:0]  man;
   logic [10:0] sig;
   logic [26:0] sig_ext;
   logic [26:0] prod;
   logic [4:0]  shift;
   logic [4:0]  shift_m1;
   logic [26:0] shifted;
   logic [26:0] round_vec;
   logic [26:0] sticky_mask;
   logic        round_bit;
   logic        sticky;
   logic [16:0] q_rnd;
   logic [15:0] kmax;

   assign sgn = half_bits[15];
   assign ex  = half_bits[14:10];
   assign man = half_bits[9:0];

   // Significand with the hidden bit, and the exact product by the scale.
   assign sig     = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
   assign sig_ext = {16'd0, sig};
   assign prod    = wide ? ({sig, 16'd0} - sig_ext) : ({8'd0, sig, 8'd0} - sig_ext);

   // Right shift of 25 - exponent; subnormals shift by 24.
   assign shift    = (ex == 5'd0) ? 5'd24 : (5'd25 - ex);
   assign shift_m1 = shift - 5'd1;

   // Rounding: guard bit and sticky bits below the kept part.
   assign shifted     = prod >> shift;
   assign round_vec   = prod >> shift_m1;
   assign round_bit   = round_vec[0];
   assign sticky_mask = (27'd1 << shift_m1) - 27'd1;
   assign sticky      = |(prod & sticky_mask);
   assign q_rnd       = {1'b0, shifted[15:0]} +
                        {16'd0, round_bit & (sticky | shifted[0])};

   assign kmax = wide ? 16'hFFFF : 16'h00FF;

   // Special values first; any value of one or more saturates.
   always_comb begin
      if (ex == 5'd31) begin
         scaled = (man != 10'd0 || sgn) ? 16'd0 : kmax;
      end else if (sgn) begin
         scaled = 16'd0;
      end else if (ex >= 5'd15) begin
         scaled = kmax;
      end else if (q_rnd > {1'b0, kmax}) begin
         scaled = kmax;
      end else begin
         scaled = q_rnd[15:0];
      end
   end

endmodule

// ===== hdl/psc_sample_conv.sv =====
// ----------------------------------------------------------------------------
// Sample converter
// Turns one plane sample into a channel byte, or a high and low byte pair.
// ----------------------------------------------------------------------------
module psc_sample_conv
   import psc_pkg::*;
(
   input  conv_ctrl_type ctrl,
   input  logic [15:0]   sample,
   output logic [7:0]    out_high,
   output logic [7:0]    out_low
);

   logic [15:0] half_val;
   logic [8:0]  word_sum;

   psc_half_scale u_half_scale (
      .half_bits (sample),
      .wide      (ctrl.stack),
      .scaled    (half_val)
   );

   // 16-bit word reduced to a byte with the top bit of the low byte as carry.
   assign word_sum = {1'b0, sample[15:8]} + {8'd0, sample[7]};

   // Select by precision; unknown precision falls back to 8-bit.
   always_comb begin
      out_high = sample[7:0];
      out_low  = 8'd0;
      unique case (ctrl.precision)
         PREC_16BIT: begin
            if (ctrl.stack) begin
               out_high = sample[15:8];
               out_low  = sample[7:0];
            end else begin
               out_high = word_sum[8] ? 8'hFF : word_sum[7:0];
            end
         end
         PREC_HALF: begin
            if (ctrl.stack) begin
               out_high = half_val[15:8];
               out_low  = half_val[7:0];
            end else begin
               out_high = half_val[7:0];
            end
         end
         default: begin
            out_high = sample[7:0];
            out_low  = 8'd0;
         end
      endcase
   end

endmodule

// ===== hdl/planar_sample_to_8bit_converter.sv =====
// ----------------------------------------------------------------------------
// Planar sample to 8-bit converter
// Converts one pixel of three plane samples to 8-bit channels each cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one pixel per transaction: three 16-bit plane
//   samples holding bytes, 16-bit words or half floats, as csr_ selects.
//   The rsp_ channel returns one transaction per pixel: three channel bytes
//   and three low bytes, which are zero unless stacked output is active.
//   Packed RGB layouts deliver blue first; the planar layout keeps order.
//   From acceptance to rsp_valid the samples are captured in an input
//   register, converted by combinational logic and held in the result
//   register. Throughput is one pixel per cycle while the receiver does
//   not stall, set by the single conversion stage between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; req_ready falls only when both are occupied.
//   Reset empties both registers and loads 16-bit precision, planar layout
//   and unstacked output. Configuration may be written only while no
//   transaction is in flight; writes take effect on the next clock.
// ----------------------------------------------------------------------------
`include "planar_sample_to_8bit_converter_assert.svh"

module planar_sample_to_8bit_converter
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_write_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_plane0_sample,
   input  logic [15:0] req_plane1_sample,
   input  logic [15:0] req_plane2_sample,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_chan0_high,
   output logic [7:0]  rsp_chan1_high,
   output logic [7:0]  rsp_chan2_high,
   output logic [7:0]  rsp_chan0_low,
   output logic [7:0]  rsp_chan1_low,
   output logic [7:0]  rsp_chan2_low
);

   logic [1:0]    precision_ff;
   logic [1:0]    layout_ff;
   logic          stacked_ff;
   logic          in_valid_ff;
   logic [15:0]   p0_ff;
   logic [15:0]   p1_ff;
   logic [15:0]   p2_ff;
   logic          out_valid_ff;
   logic [7:0]    hi0_ff, hi1_ff, hi2_ff;
   logic [7:0]    lo0_ff, lo1_ff, lo2_ff;
   logic          out_load;
   logic          in_advance;
   logic          rgb;
   conv_ctrl_type ctrl;
   logic [15:0]   first_in;
   logic [15:0]   last_in;
   logic [7:0]    hi0_in, hi1_in, hi2_in;
   logic [7:0]    lo0_in, lo1_in, lo2_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= RESET_PRECISION;
         layout_ff    <= RESET_LAYOUT;
         stacked_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SAMPLE_PRECISION: precision_ff <= csr_write_data;
            CSR_OUTPUT_LAYOUT:    layout_ff    <= csr_write_data;
            CSR_STACKED_16BIT:    stacked_ff   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Handshake: the result register loads when empty or being drained.
   assign out_load   = !out_valid_ff || rsp_ready;
   assign in_advance = in_valid_ff && out_load;
   assign req_ready  = !in_valid_ff || out_load;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         p0_ff <= req_plane0_sample;
         p1_ff <= req_plane1_sample;
         p2_ff <= req_plane2_sample;
      end
   end

   // Mode decode and channel order.
   assign rgb            = (layout_ff != LAYOUT_PLANAR);
   assign ctrl.precision = precision_ff;
   assign ctrl.stack     = stacked_ff && !rgb &&
                           (precision_ff == PREC_16BIT || precision_ff == PREC_HALF);
   assign first_in       = rgb ? p2_ff : p0_ff;
   assign last_in        = rgb ? p0_ff : p2_ff;

   psc_sample_conv u_conv0 (
      .ctrl (ctrl), .sample (first_in), .out_high (hi0_in), .out_low (lo0_in)
   );

   psc_sample_conv u_conv1 (
      .ctrl (ctrl), .sample (p1_ff), .out_high (hi1_in), .out_low (lo1_in)
   );

   psc_sample_conv u_conv2 (
      .ctrl (ctrl), .sample (last_in), .out_high (hi2_in), .out_low (lo2_in)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         hi0_ff <= hi0_in;
         hi1_ff <= hi1_in;
         hi2_ff <= hi2_in;
         lo0_ff <= lo0_in;
         lo1_ff <= lo1_in;
         lo2_ff <= lo2_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_chan0_high = hi0_ff;
   assign rsp_chan1_high = hi1_ff;
   assign rsp_chan2_high = hi2_ff;
   assign rsp_chan0_low  = lo0_ff;
   assign rsp_chan1_low  = lo1_ff;
   assign rsp_chan2_low  = lo2_ff;

   // Checks on the pipeline control.
   `PSC_ASSERT_IMPLIES(a_ready_blocked_only_when_full, clock, reset, !req_ready, in_valid_ff && out_valid_ff)
   `PSC_ASSERT_NEXT(a_held_input_stays, clock, reset, in_valid_ff && !out_load, in_valid_ff && $stable(p0_ff) && $stable(p1_ff) && $stable(p2_ff))
   `PSC_ASSERT_NEXT(a_input_reaches_output, clock, reset, in_advance, out_valid_ff)
   `PSC_ASSERT_IMPLIES(a_rgb_low_bytes_zero, clock, reset, out_valid_ff && rgb, lo0_ff == 8'd0 && lo1_ff == 8'd0 && lo2_ff == 8'd0)

endmodule

// ===== sim/planar_sample_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Planar sample converter checker
// Watches the configuration port and both channels of the converter. It keeps
// its own copy of the registers, predicts the channel bytes of every accepted
// pixel and compares each response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module planar_sample_checker
   import psc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_plane0_sample,
   input  logic [15:0] req_plane1_sample,
   input  logic [15:0] req_plane2_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_chan0_high,
   input  logic [7:0]  rsp_chan1_high,
   input  logic [7:0]  rsp_chan2_high,
   input  logic [7:0]  rsp_chan0_low,
   input  logic [7:0]  rsp_chan1_low,
   input  logic [7:0]  rsp_chan2_low,
   output int          error_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0] chan0_high;
      logic [7:0] chan1_high;
      logic [7:0] chan2_high;
      logic [7:0] chan0_low;
      logic [7:0] chan1_low;
      logic [7:0] chan2_low;
   } pixel_bytes_type;

   // Shadow copy of the configuration registers.
   logic [1:0] cfg_precision;
   logic [1:0] cfg_layout;
   logic       cfg_stacked;

   // Predicted pixels, oldest first.
   pixel_bytes_type expected_pixels[$];

   // Half-float value times 255 (or 65535 when wide), formed exactly, rounded
   // to nearest with ties to even and clamped. NaN and negatives give zero.
   function automatic logic [15:0] scale_half(input logic [15:0] bits, input bit wide);
      logic [63:0] k;
      logic [63:0] sig;
      logic [63:0] prod;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] halfway;
      int          exp2;
      int          shift;
      k = wide ? 64'd65535 : 64'd255;
      if (bits[14:10] == 5'h1F) begin
         return (bits[9:0] != 10'd0 || bits[15]) ? 16'd0 : k[15:0];
      end
      if (bits[15]) begin
         return 16'd0;
      end
      if (bits[14:10] == 5'd0) begin
         sig = {54'd0, bits[9:0]};
         exp2 = -24;
      end else begin
         sig = 64'd1024 + {54'd0, bits[9:0]};
         exp2 = int'(bits[14:10]) - 25;
      end
      prod = sig * k;
      if (exp2 >= 0) begin
         q = prod << exp2;
      end else begin
         shift = -exp2;
         q = prod >> shift;
         rem = prod & ((64'd1 << shift) - 64'd1);
         halfway = 64'd1 << (shift - 1);
         if (rem > halfway || (rem == halfway && q[0])) begin
            q = q + 64'd1;
         end
      end
      if (q > k) begin
         q = k;
      end
      return q[15:0];
   endfunction

   // One sample to its high and low output bytes under the current precision.
   function automatic logic [15:0] convert_sample(input logic [15:0] s, input bit split);
      logic [8:0]  sum;
      logic [15:0] v;
      case (cfg_precision)
         PREC_16BIT: begin
            if (split) begin
               return s;
            end
            sum = s[15:8] + s[7];
            return {(sum > 9'd255) ? 8'hFF : sum[7:0], 8'h00};
         end
         PREC_HALF: begin
            if (split) begin
               return scale_half(s, 1'b1);
            end
            v = scale_half(s, 1'b0);
            return {v[7:0], 8'h00};
         end
         default: begin
            // The zero code behaves as 8-bit samples; the upper byte is ignored.
            return {s[7:0], 8'h00};
         end
      endcase
   endfunction

   // Expected response for one pixel. Packed RGB puts blue first and never
   // splits, nor do 8-bit samples.
   function automatic pixel_bytes_type predict_pixel(input logic [15:0] s0, s1, s2);
      pixel_bytes_type px;
      logic [15:0]     c0;
      logic [15:0]     c1;
      logic [15:0]     c2;
      bit              rgb_order;
      bit              split;
      rgb_order = (cfg_layout != LAYOUT_PLANAR);
      split = cfg_stacked && !rgb_order &&
              (cfg_precision == PREC_16BIT || cfg_precision == PREC_HALF);
      c0 = convert_sample(rgb_order ? s2 : s0, split);
      c1 = convert_sample(s1, split);
      c2 = convert_sample(rgb_order ? s0 : s2, split);
      px.chan0_high = c0[15:8];
      px.chan1_high = c1[15:8];
      px.chan2_high = c2[15:8];
      px.chan0_low  = c0[7:0];
      px.chan1_low  = c1[7:0];
      px.chan2_low  = c2[7:0];
      return px;
   endfunction

   task automatic check_field(input string field, input logic [7:0] want, got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         error_count++;
      end
   endtask

   // Register writes take effect on the next clock, so predictions made at
   // the same edge still use the old settings.
   always @(posedge clock) begin : monitor
      pixel_bytes_type want;
      if (reset) begin
         cfg_precision <= RESET_PRECISION;
         cfg_layout    <= RESET_LAYOUT;
         cfg_stacked   <= 1'b0;
         expected_pixels.delete();
         error_count = 0;
         pending_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SAMPLE_PRECISION: cfg_precision <= csr_write_data;
               CSR_OUTPUT_LAYOUT:    cfg_layout    <= csr_write_data;
               CSR_STACKED_16BIT:    cfg_stacked   <= csr_write_data[0];
               default: ;
            endcase
         end

         // Compare a completed response transaction with the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("response transaction arrived with no pixel outstanding");
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("chan0_high", want.chan0_high, rsp_chan0_high);
               check_field("chan1_high", want.chan1_high, rsp_chan1_high);
               check_field("chan2_high", want.chan2_high, rsp_chan2_high);
               check_field("chan0_low", want.chan0_low, rsp_chan0_low);
               check_field("chan1_low", want.chan1_low, rsp_chan1_low);
               check_field("chan2_low", want.chan2_low, rsp_chan2_low);
            end
         end

         if (req_valid && req_ready) begin
            expected_pixels.push_back(predict_pixel(req_plane0_sample,
                                                    req_plane1_sample,
                                                    req_plane2_sample));
         end
         pending_count = expected_pixels.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Planar sample converter testbench
// Drives pixels through the converter under every register setting, with
// directed corner values first and then random samples, while both sides
// idle at varying rates. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_top;
   import psc_pkg::*;

   // Codes not named in the package.
   localparam logic [1:0] PREC_NONE       = 2'd0;
   localparam logic [1:0] LAYOUT_RGB24    = 2'd1;
   localparam logic [1:0] LAYOUT_RGB32    = 2'd2;
   localparam logic [1:0] LAYOUT_RESERVED = 2'd3;
   localparam logic [1:0] CSR_UNUSED      = 2'd3;

   localparam int PIXELS_PER_SETTING = 14;
   localparam int HOLD_CYCLES        = 300;
   // Well above the longest quiet stretch of a correct run, the long hold.
   localparam int WATCHDOG_LIMIT     = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [1:0]  csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_plane0_sample;
   logic [15:0] req_plane1_sample;
   logic [15:0] req_plane2_sample;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_chan0_high;
   logic [7:0]  rsp_chan1_high;
   logic [7:0]  rsp_chan2_high;
   logic [7:0]  rsp_chan0_low;
   logic [7:0]  rsp_chan1_low;
   logic [7:0]  rsp_chan2_low;
   int          error_count;
   int          pending_count;

   int gap_pct;
   int stall_pct;
   bit hold_request;
   int quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   planar_sample_to_8bit_converter i_dut (.*);

   planar_sample_checker i_checker (.*);

   // Offer one pixel after a random gap and wait until it is taken. Readiness
   // is sampled at the falling edge, where it has settled for the next edge.
   task automatic offer_pixel(input logic [15:0] s0, s1, s2);
      bit taken;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_plane0_sample <= s0;
      req_plane1_sample <= s1;
      req_plane2_sample <= s2;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Stop offering and wait until every outstanding pixel has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Write all registers back to back; the unused index is written first
   // and must change nothing.
   task automatic apply_settings(input logic [1:0] precision, layout, input logic stacked);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= 2'b11;
      @(posedge clock);
      csr_index      <= CSR_SAMPLE_PRECISION;
      csr_write_data <= precision;
      @(posedge clock);
      csr_index      <= CSR_OUTPUT_LAYOUT;
      csr_write_data <= layout;
      @(posedge clock);
      csr_index      <= CSR_STACKED_16BIT;
      csr_write_data <= {1'b0, stacked};
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random sample, biased towards the interesting regions of each encoding.
   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 5))
         0, 1: return 16'($urandom);
         // Halves from zero to just above one, where rounding matters.
         2: return 16'($urandom_range(0, 16'h3C08));
         // Words close to the clamp of the 16-bit rounding.
         3: return {8'hFF, 8'($urandom)};
         // Subnormal halves of either sign.
         4: return 16'($urandom) & 16'h83FF;
         default: begin
            case ($urandom_range(0, 7))
               0: return 16'h7C00;
               1: return 16'hFC00;
               2: return 16'h7E00;
               3: return 16'h8000;
               4: return 16'h0000;
               5: return 16'h7BFF;
               6: return 16'hFFFF;
               default: return 16'h3C00;
            endcase
         end
      endcase
   endfunction

   // Receiver: random stalls, or one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict.
   initial begin
      int phase;
      int n;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_SAMPLE_PRECISION;
      csr_write_data    = 2'd0;
      req_valid         = 1'b0;
      req_plane0_sample = 16'd0;
      req_plane1_sample = 16'd0;
      req_plane2_sample = 16'd0;
      gap_pct           = 0;
      stall_pct         = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings after reset: 16-bit words, planar order, unstacked.
      offer_pixel(16'h0000, 16'hFFFF, 16'h0080);
      offer_pixel(16'h007F, 16'hFF80, 16'hFF7F);

      // Half floats: infinities, NaN, minus zero, one and the extremes.
      wait_for_drain();
      apply_settings(PREC_HALF, LAYOUT_PLANAR, 1'b0);
      offer_pixel(16'h7C00, 16'hFC00, 16'h7E00);
      offer_pixel(16'h8000, 16'h3C00, 16'h0001);
      offer_pixel(16'h7BFF, 16'h3800, 16'h2008);
      offer_pixel(16'hFE01, 16'h7C01, 16'h1C04);

      // Half floats split into two bytes.
      wait_for_drain();
      apply_settings(PREC_HALF, LAYOUT_PLANAR, 1'b1);
      offer_pixel(16'h7C00, 16'h3C00, 16'h7BFF);
      offer_pixel(16'h3555, 16'h0400, 16'h03FF);

      // 16-bit words split into two bytes.
      wait_for_drain();
      apply_settings(PREC_16BIT, LAYOUT_PLANAR, 1'b1);
      offer_pixel(16'hABCD, 16'h00FF, 16'hFF00);

      // 8-bit samples in RGB order; the upper byte must be ignored.
      wait_for_drain();
      apply_settings(PREC_8BIT, LAYOUT_RGB24, 1'b0);
      offer_pixel(16'h12AB, 16'hFF00, 16'h00FF);

      // Precision code zero and layout code three, with stacking ignored.
      wait_for_drain();
      apply_settings(PREC_NONE, LAYOUT_RESERVED, 1'b1);
      offer_pixel(16'hA55A, 16'h5AA5, 16'hFFFF);

      // Stacking requested with packed RGB layouts is ignored.
      wait_for_drain();
      apply_settings(PREC_16BIT, LAYOUT_RGB32, 1'b1);
      offer_pixel(16'hABCD, 16'h8080, 16'hFFFF);
      wait_for_drain();
      apply_settings(PREC_HALF, LAYOUT_RGB24, 1'b1);
      offer_pixel(16'h7C00, 16'h3C00, 16'h0000);

      // Random pixels under every combination of the three registers.
      for (phase = 0; phase < 32; phase++) begin
         wait_for_drain();
         apply_settings(phase[4:3], phase[2:1], phase[0]);
         case ($urandom_range(0, 3))
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 71;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 71;
            end
            default: begin
               gap_pct = 16;
               stall_pct = 16;
            end
         endcase
         // Once, hold the receiver off while pixels keep coming, so that
         // both registers fill and the input stalls.
         if (phase == 9) begin
            gap_pct = 0;
            stall_pct = 0;
            hold_request = 1'b1;
         end
         for (n = 0; n < PIXELS_PER_SETTING; n++) begin
            offer_pixel(random_sample(), random_sample(), random_sample());
         end
      end

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/psc_pkg.sv
hdl/psc_half_scale.sv
hdl/psc_sample_conv.sv
hdl/planar_sample_to_8bit_converter.sv
sim/planar_sample_checker.sv
sim/tb_top.sv
